>>> design/bffpa_pkg.sv
// ----------------------------------------------------------------------------
// bffpa_pkg: shared types and constants for the first-fit page allocator
// Command codes, controller states and the control/status bundles that run
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package bffpa_pkg;

    localparam int ADDR_W    = 24;   // byte address width
    localparam int SIZE_W    = 25;   // request size width
    localparam int EW        = 26;   // wide page arithmetic (counts, ends)
    localparam int WORD_BITS = 8;    // map bits per memory word
    localparam int WORD_SH   = 3;    // log2(WORD_BITS)

    typedef enum logic [1:0] {
        OP_ALLOC     = 2'd0,
        OP_FREE_PAGE = 2'd1,
        OP_MARK_FREE = 2'd2,
        OP_MARK_USED = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_NEXT_CHK,
        S_SRCH,
        S_MARK,
        S_RESP
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;       // latch request
        logic clr_wr;     // reset sweep: write one word all used
        logic set_mark;   // set up range mark from request
        logic set_large;  // set up multi-page search, drop cursor offset
        logic set_fresh;  // set up single-page search
        logic small_fit;  // bump inside current page
        logic set_next;   // point word address at the neighbor page
        logic take_next;  // spill into neighbor page
        logic srch_step;  // scan one word
        logic mark_step;  // read-modify-write one word
        logic fail;       // out of memory
        logic load_out;   // move result into output register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic clr_last;
        t_op  op;
        logic is_large;
        logic too_big;
        logic spill;
        logic next_ok;
        logic cursor_fit;
        logic next_free;
        logic srch_found;
        logic srch_last;
        logic mark_last;
        logic out_free;
    } t_sts;

endpackage

>>> design/bitmap_first_fit_page_allocator_unit.sv
// ----------------------------------------------------------------------------
// bitmap_first_fit_page_allocator_unit: first-fit page allocator
// Used-page bitmap with first-fit multi-page allocation, a sub-page bump
// cursor for small requests, and page/range free and used marking.
// ----------------------------------------------------------------------------
// Flow: a small allocation inside the current page goes from decode straight
//   to the response; a search scans one 8-page map word per cycle (up to
//   NUM_PAGES/8 words), and marking writes one map word per cycle. One
//   request at a time: the next is taken in the cycle after the response
//   loads.
// Reset: the map is swept to all used, one word a cycle, with no request
//   taken meanwhile; cursor page is 1, offset 0.
module bitmap_first_fit_page_allocator_unit import bffpa_pkg::*; #(
    parameter int NUM_PAGES   = 4096,
    parameter int PAGE_BYTES  = 4096,
    parameter int SMALL_ALIGN = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [55:0]       i_s_tdata,   // address[23:0], size[48:24], zero pad
    input  logic [1:0]        i_s_tuser,   // opcode[1:0]
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [ADDR_W-1:0] o_m_tdata,   // result_address[23:0]
    output logic [0:0]        o_m_tuser    // status[0]
);

    t_cmd w_cmd;
    t_sts w_sts;
    logic w_ostat;

    bffpa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .o_in_ready (o_s_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    bffpa_dp #(
        .NUM_PAGES   (NUM_PAGES),
        .PAGE_BYTES  (PAGE_BYTES),
        .SMALL_ALIGN (SMALL_ALIGN)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_in_op      (t_op'(i_s_tuser)),
        .i_in_addr    (i_s_tdata[ADDR_W-1:0]),
        .i_in_size    (i_s_tdata[ADDR_W+SIZE_W-1:ADDR_W]),
        .o_out_valid  (o_m_tvalid),
        .i_out_ready  (i_m_tready),
        .o_out_addr   (o_m_tdata),
        .o_out_status (w_ostat)
    );

    assign o_m_tuser = w_ostat;

    // a failed allocation never reports an address
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[0]) |-> (o_m_tdata == '0))
        else $error("failed request carries nonzero address");

    // one request in flight: ready drops right after a request is taken
    a_one_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("second request taken while busy");

    // result register only loads when it is free
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_out |-> (!o_m_tvalid || i_m_tready))
        else $error("result overwritten before taken");

endmodule

>>> design/bffpa_ctrl.sv
// ----------------------------------------------------------------------------
// bffpa_ctrl: allocator sequencer
// Walks each request through decode and, as needed, neighbor check, map
// search and map marking, then hands the result to the output register.
// ----------------------------------------------------------------------------
module bffpa_ctrl import bffpa_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (i_sts.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) n_state = S_DECODE;
            end
            S_DECODE: begin
                if (i_sts.op == OP_ALLOC) begin
                    if (i_sts.is_large) begin
                        n_state = i_sts.too_big ? S_RESP : S_SRCH;
                    end else if (i_sts.spill) begin
                        n_state = i_sts.next_ok ? S_NEXT_CHK : S_SRCH;
                    end else begin
                        n_state = i_sts.cursor_fit ? S_RESP : S_SRCH;
                    end
                end else begin
                    n_state = S_MARK;
                end
            end
            S_NEXT_CHK: begin
                n_state = i_sts.next_free ? S_MARK : S_SRCH;
            end
            S_SRCH: begin
                if (i_sts.srch_found)     n_state = S_MARK;
                else if (i_sts.srch_last) n_state = S_RESP;
            end
            S_MARK: begin
                if (i_sts.mark_last) n_state = S_RESP;
            end
            S_RESP: begin
                if (i_sts.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // commands
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_DECODE: begin
                if (i_sts.op == OP_ALLOC) begin
                    if (i_sts.is_large) begin
                        o_cmd.set_large = 1'b1;
                        o_cmd.fail      = i_sts.too_big;
                    end else if (i_sts.spill) begin
                        o_cmd.set_next  = i_sts.next_ok;
                        o_cmd.set_fresh = !i_sts.next_ok;
                    end else begin
                        o_cmd.small_fit = i_sts.cursor_fit;
                        o_cmd.set_fresh = !i_sts.cursor_fit;
                    end
                end else begin
                    o_cmd.set_mark = 1'b1;
                end
            end
            S_NEXT_CHK: begin
                o_cmd.take_next = i_sts.next_free;
                o_cmd.set_fresh = !i_sts.next_free;
            end
            S_SRCH: begin
                o_cmd.srch_step = 1'b1;
                o_cmd.fail      = !i_sts.srch_found && i_sts.srch_last;
            end
            S_MARK: begin
                o_cmd.mark_step = 1'b1;
            end
            S_RESP: begin
                o_cmd.load_out = i_sts.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

>>> design/bffpa_dp.sv
// ----------------------------------------------------------------------------
// bffpa_dp: allocator datapath
// Used-page map memory (8 pages per word), sub-page cursor, search and
// marking logic, and the result output register.
// ----------------------------------------------------------------------------
module bffpa_dp import bffpa_pkg::*; #(
    parameter int NUM_PAGES   = 4096,
    parameter int PAGE_BYTES  = 4096,
    parameter int SMALL_ALIGN = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_sts              o_sts,
    input  t_op               i_in_op,
    input  logic [ADDR_W-1:0] i_in_addr,
    input  logic [SIZE_W-1:0] i_in_size,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [ADDR_W-1:0] o_out_addr,
    output logic              o_out_status
);

    localparam int PG_W  = $clog2(NUM_PAGES);
    localparam int PB_SH = $clog2(PAGE_BYTES);
    localparam int AL_SH = $clog2(SMALL_ALIGN);
    localparam int OFF_W = PB_SH;
    localparam int NW    = NUM_PAGES / WORD_BITS;
    localparam int WA_W  = PG_W - WORD_SH;

    // round up to alignment; a full page wraps to zero
    function automatic logic [OFF_W-1:0] next_off(input logic [OFF_W:0] v);
        logic [OFF_W:0] r;
        r = ((v + (OFF_W+1)'(SMALL_ALIGN - 1)) >> AL_SH) << AL_SH;
        return (r >= (OFF_W+1)'(PAGE_BYTES)) ? '0 : r[OFF_W-1:0];
    endfunction

    logic [WORD_BITS-1:0] r_mem [NW];
    logic [WORD_BITS-1:0] r_rdata;

    t_op               r_op;
    logic [ADDR_W-1:0] r_addr;
    logic [SIZE_W-1:0] r_size;
    logic [PG_W-1:0]   r_cpage;
    logic [OFF_W-1:0]  r_coff;
    logic [EW-1:0]     r_first, r_end, r_need, r_run, r_cand;
    logic              r_mval, r_large;
    logic [WA_W-1:0]   r_waddr, n_waddr, r_clr;
    logic [ADDR_W-1:0] r_res, r_oaddr;
    logic              r_stat, r_ostat, r_ovalid;

    logic [EW-1:0]        pg_in, pages_sz, cnt, msum, mend, base;
    logic [OFF_W-1:0]     sz_s, spill_off;
    logic [OFF_W:0]       v_fit;
    logic [PG_W:0]        nxt;
    logic                 spill;
    logic [EW-1:0]        run, cand, fstart;
    logic                 found;
    logic [WORD_BITS-1:0] mask, wd, mem_wd;
    logic                 we;
    logic [WA_W-1:0]      wa;

    // request decode
    always_comb begin
        pg_in     = EW'(r_addr >> PB_SH);
        pages_sz  = (EW'(r_size) + EW'(PAGE_BYTES - 1)) >> PB_SH;
        cnt       = (r_op == OP_FREE_PAGE) ? EW'(1) : pages_sz;
        msum      = pg_in + cnt;
        mend      = (msum > EW'(NUM_PAGES)) ? EW'(NUM_PAGES) : msum;
        sz_s      = (r_size == '0) ? OFF_W'(1) : r_size[OFF_W-1:0];
        v_fit     = {1'b0, r_coff} + {1'b0, sz_s};
        spill     = v_fit > (OFF_W+1)'(PAGE_BYTES);
        spill_off = next_off(v_fit - (OFF_W+1)'(PAGE_BYTES));
        nxt       = {1'b0, r_cpage} + (PG_W+1)'(1);
        base      = EW'({r_waddr, {WORD_SH{1'b0}}});
    end

    // free-run scan over one word
    always_comb begin
        run    = r_run;
        cand   = r_cand;
        found  = 1'b0;
        fstart = r_cand;
        for (int i = 0; i < WORD_BITS; i++) begin
            if (!found) begin
                if (r_rdata[i]) begin
                    run = '0;
                end else begin
                    if (run == '0) cand = base + EW'(i);
                    run = run + EW'(1);
                    if (run >= r_need) begin
                        found  = 1'b1;
                        fstart = cand;
                    end
                end
            end
        end
    end

    // range mask for one word
    always_comb begin
        for (int i = 0; i < WORD_BITS; i++) begin
            mask[i] = ((base + EW'(i)) >= r_first) && ((base + EW'(i)) < r_end);
        end
        wd = r_mval ? (r_rdata | mask) : (r_rdata & ~mask);
    end

    // status to controller
    always_comb begin
        o_sts.clr_last   = r_clr == WA_W'(NW - 1);
        o_sts.op         = r_op;
        o_sts.is_large   = r_size >= SIZE_W'(PAGE_BYTES);
        o_sts.too_big    = pages_sz > EW'(NUM_PAGES);
        o_sts.spill      = spill;
        o_sts.next_ok    = nxt < (PG_W+1)'(NUM_PAGES);
        o_sts.cursor_fit = !spill && (r_coff != '0);
        o_sts.next_free  = !r_rdata[nxt[WORD_SH-1:0]];
        o_sts.srch_found = found;
        o_sts.srch_last  = r_waddr == WA_W'(NW - 1);
        o_sts.mark_last  = ((base + EW'(WORD_BITS)) >= r_end)
                           || (r_waddr == WA_W'(NW - 1));
        o_sts.out_free   = !r_ovalid || i_out_ready;
    end

    // word address sequencing (read address is the next word address)
    always_comb begin
        n_waddr = r_waddr;
        if (i_cmd.set_mark) begin
            n_waddr = WA_W'(pg_in >> WORD_SH);
        end else if (i_cmd.set_large || i_cmd.set_fresh) begin
            n_waddr = '0;
        end else if (i_cmd.set_next) begin
            n_waddr = nxt[PG_W-1:WORD_SH];
        end else if (i_cmd.srch_step) begin
            n_waddr = found ? WA_W'(fstart >> WORD_SH) : r_waddr + WA_W'(1);
        end else if (i_cmd.mark_step) begin
            n_waddr = r_waddr + WA_W'(1);
        end
    end

    // write port select
    always_comb begin
        we     = i_cmd.clr_wr || i_cmd.mark_step;
        wa     = i_cmd.clr_wr ? r_clr : r_waddr;
        mem_wd = i_cmd.clr_wr ? '1 : wd;
    end

    // map memory, registered read with write bypass
    always_ff @(posedge i_clk) begin
        if (we) r_mem[wa] <= mem_wd;
        if (we && (wa == n_waddr)) begin
            r_rdata <= mem_wd;
        end else begin
            r_rdata <= r_mem[n_waddr];
        end
    end

    // cursor, sweep counter, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cpage  <= PG_W'(1);
            r_coff   <= '0;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.clr_wr) r_clr <= r_clr + WA_W'(1);
            if (i_cmd.set_large) r_coff <= '0;
            if (i_cmd.small_fit) r_coff <= next_off(v_fit);
            if (i_cmd.take_next) begin
                r_cpage <= nxt[PG_W-1:0];
                r_coff  <= spill_off;
            end
            if (i_cmd.srch_step && found && !r_large) begin
                r_cpage <= fstart[PG_W-1:0];
                r_coff  <= next_off({1'b0, sz_s});
            end
            if (i_cmd.load_out)   r_ovalid <= 1'b1;
            else if (i_out_ready) r_ovalid <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_waddr <= n_waddr;
        if (i_cmd.load) begin
            r_op   <= i_in_op;
            r_addr <= i_in_addr;
            r_size <= i_in_size;
            r_res  <= '0;
            r_stat <= 1'b0;
        end
        if (i_cmd.set_mark) begin
            r_first <= pg_in;
            r_end   <= mend;
            r_mval  <= r_op == OP_MARK_USED;
        end
        if (i_cmd.set_large) begin
            r_need  <= pages_sz;
            r_run   <= '0;
            r_large <= 1'b1;
        end
        if (i_cmd.set_fresh) begin
            r_need  <= EW'(1);
            r_run   <= '0;
            r_large <= 1'b0;
        end
        if (i_cmd.small_fit) r_res <= ADDR_W'({r_cpage, r_coff});
        if (i_cmd.take_next) begin
            r_res   <= ADDR_W'({r_cpage, r_coff});
            r_first <= EW'(nxt);
            r_end   <= EW'(nxt) + EW'(1);
            r_mval  <= 1'b1;
        end
        if (i_cmd.srch_step) begin
            r_run  <= run;
            r_cand <= cand;
            if (found) begin
                r_res   <= ADDR_W'({fstart[PG_W-1:0], {PB_SH{1'b0}}});
                r_first <= fstart;
                r_end   <= fstart + (r_large ? r_need : EW'(1));
                r_mval  <= 1'b1;
            end
        end
        if (i_cmd.fail) begin
            r_res  <= '0;
            r_stat <= 1'b1;
        end
        if (i_cmd.load_out) begin
            r_oaddr <= r_res;
            r_ostat <= r_stat;
        end
    end

    assign o_out_valid  = r_ovalid;
    assign o_out_addr   = r_oaddr;
    assign o_out_status = r_ostat;

endmodule
